>>> rtl/idll_pkg.sv
// shared types and codes for the indexed doubly linked list
// no dependencies; used by the top level
package idll_pkg;

    localparam int SLOTS_DEFAULT = 1024;

    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 10;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_SLOT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] node_index;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  slot;
        logic [FIELD_W-1:0]  next_link;
        logic [FIELD_W-1:0]  prev_link;
        logic [FIELD_W-1:0]  list_size;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

>>> rtl/indexed_doubly_linked_list_top.sv
// Indexed circular doubly linked list with a free chain of unused slots.
// Slot 0 is the sentinel (next link = head, previous link = tail). After reset the
// block sweeps both link memories, one entry per cycle, holding cmd_ready low until
// that pass is done. Commands are then taken one at a time: a read looks up its
// slot; a delete reads the slot, bridges its neighbours and frees it; an insert
// reads the anchor slot, then the free head, writes the new slot and splices it in.
// Head or tail deletes and tail inserts read the sentinel first. A bad index, a
// delete from an empty list or an unused code needs no link lookup; an unlinked
// slot or a full list answers after a lookup. The order is set by the single read
// port of each link memory: every dependent link lookup costs one registered read.
// A finished result waits in an output register while the next command is taken.
// depends on idll_pkg and idll_ram
module indexed_doubly_linked_list_top #(
    parameter int SLOTS = idll_pkg::SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  idll_pkg::cmd_t    cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output idll_pkg::rsp_t    rsp_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int FW = idll_pkg::FIELD_W;
    localparam logic [LW-1:0] CHAIN_END = LW'(SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        ROOT_GOT,
        NODE_GOT,
        INS_FREE,
        INS_SPLICE,
        DEL_FREE,
        RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [idll_pkg::CMD_W-1:0]   op_reg, op_next;
    logic [IW-1:0]                addr_reg, addr_next;
    logic [IW-1:0]                after_reg, after_next;
    logic [IW-1:0]                slot_reg, slot_next;
    logic [IW-1:0]                clr_reg, clr_next;
    logic [LW-1:0]                free_head_reg, free_head_next;
    logic [LW-1:0]                count_reg, count_next;
    idll_pkg::rsp_t               res_reg, res_next;
    idll_pkg::rsp_t               rsp_data_reg, rsp_data_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    // link memories; previous links carry a live bit on top
    logic          next_we, prev_we;
    logic [IW-1:0] next_waddr, next_raddr, prev_waddr, prev_raddr;
    logic [LW-1:0] next_wdata, next_rdata;
    logic [IW:0]   prev_wdata, prev_rdata;

    logic          idx_range;
    logic          root_cmd;
    logic          node_live;
    logic [IW-1:0] root_sel;

    idll_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    idll_ram #(.WIDTH(IW + 1), .DEPTH(SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    function automatic idll_pkg::rsp_t make_rsp(
        input logic [FW-1:0]                 s,
        input logic [FW-1:0]                 nl,
        input logic [FW-1:0]                 pl,
        input logic [FW-1:0]                 sz,
        input logic [idll_pkg::STATUS_W-1:0] st
    );
        idll_pkg::rsp_t r;
        r.slot      = s;
        r.next_link = nl;
        r.prev_link = pl;
        r.list_size = sz;
        r.status    = st;
        return r;
    endfunction

    assign idx_range = int'(cmd_data.node_index) >= SLOTS;
    assign root_cmd  = (cmd_data.cmd == idll_pkg::CMD_INS_TAIL) ||
                       (cmd_data.cmd == idll_pkg::CMD_DEL_HEAD) ||
                       (cmd_data.cmd == idll_pkg::CMD_DEL_TAIL);
    assign node_live = prev_rdata[IW];
    assign root_sel  = (op_reg == idll_pkg::CMD_DEL_HEAD) ? IW'(next_rdata)
                                                          : prev_rdata[IW-1:0];

    assign cmd_ready = (state_reg == IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        after_next     = after_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg;

        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        next_raddr = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        prev_raddr = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            CLEAR:
            begin
                next_we    = 1'b1;
                next_waddr = clr_reg;
                next_wdata = (clr_reg == '0) ? '0 : LW'(clr_reg) + LW'(1);
                prev_we    = 1'b1;
                prev_waddr = clr_reg;
                prev_wdata = '0;
                clr_next   = clr_reg + IW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = IDLE;
                end
            end

            IDLE:
            begin
                // root commands look at the sentinel first
                next_raddr = root_cmd ? '0 : IW'(cmd_data.node_index);
                prev_raddr = root_cmd ? '0 : IW'(cmd_data.node_index);
                if (cmd_valid)
                begin
                    op_next   = cmd_data.cmd;
                    addr_next = IW'(cmd_data.node_index);
                    case (cmd_data.cmd)
                        idll_pkg::CMD_INS_AFTER, idll_pkg::CMD_READ:
                        begin
                            if (idx_range)
                            begin
                                res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                      idll_pkg::ST_RANGE);
                                state_next = RESP;
                            end
                            else
                            begin
                                state_next = NODE_GOT;
                            end
                        end
                        idll_pkg::CMD_DEL_SLOT:
                        begin
                            if (idx_range || cmd_data.node_index == '0)
                            begin
                                res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                      idll_pkg::ST_RANGE);
                                state_next = RESP;
                            end
                            else
                            begin
                                state_next = NODE_GOT;
                            end
                        end
                        idll_pkg::CMD_INS_TAIL:
                        begin
                            state_next = ROOT_GOT;
                        end
                        idll_pkg::CMD_DEL_HEAD, idll_pkg::CMD_DEL_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                      idll_pkg::ST_EMPTY);
                                state_next = RESP;
                            end
                            else
                            begin
                                state_next = ROOT_GOT;
                            end
                        end
                        default:
                        begin
                            res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                  idll_pkg::ST_OK);
                            state_next = RESP;
                        end
                    endcase
                end
            end

            ROOT_GOT:
            begin
                addr_next  = root_sel;
                next_raddr = root_sel;
                prev_raddr = root_sel;
                state_next = NODE_GOT;
            end

            NODE_GOT:
            begin
                case (op_reg)
                    idll_pkg::CMD_INS_AFTER, idll_pkg::CMD_INS_TAIL:
                    begin
                        if (addr_reg != '0 && !node_live)
                        begin
                            res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                  idll_pkg::ST_RANGE);
                            state_next = RESP;
                        end
                        else if (free_head_reg == CHAIN_END)
                        begin
                            res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                  idll_pkg::ST_FULL);
                            state_next = RESP;
                        end
                        else
                        begin
                            after_next = IW'(next_rdata);
                            slot_next  = IW'(free_head_reg);
                            next_raddr = IW'(free_head_reg);
                            state_next = INS_FREE;
                        end
                    end
                    idll_pkg::CMD_DEL_SLOT, idll_pkg::CMD_DEL_HEAD,
                    idll_pkg::CMD_DEL_TAIL:
                    begin
                        if (!node_live)
                        begin
                            res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                                  idll_pkg::ST_RANGE);
                            state_next = RESP;
                        end
                        else
                        begin
                            // bridge the neighbors over the removed slot
                            next_we    = 1'b1;
                            next_waddr = prev_rdata[IW-1:0];
                            next_wdata = next_rdata;
                            prev_we    = 1'b1;
                            prev_waddr = IW'(next_rdata);
                            prev_wdata = {(IW'(next_rdata) != '0), prev_rdata[IW-1:0]};
                            state_next = DEL_FREE;
                        end
                    end
                    idll_pkg::CMD_READ:
                    begin
                        res_next   = make_rsp(FW'(addr_reg), FW'(next_rdata),
                                              FW'(prev_rdata[IW-1:0]), FW'(count_reg),
                                              idll_pkg::ST_OK);
                        state_next = RESP;
                    end
                    default:
                    begin
                        res_next   = make_rsp('0, '0, '0, FW'(count_reg),
                                              idll_pkg::ST_OK);
                        state_next = RESP;
                    end
                endcase
            end

            INS_FREE:
            begin
                free_head_next = next_rdata;
                next_we        = 1'b1;
                next_waddr     = slot_reg;
                next_wdata     = LW'(after_reg);
                prev_we        = 1'b1;
                prev_waddr     = slot_reg;
                prev_wdata     = {1'b1, addr_reg};
                state_next     = INS_SPLICE;
            end

            INS_SPLICE:
            begin
                next_we    = 1'b1;
                next_waddr = addr_reg;
                next_wdata = LW'(slot_reg);
                prev_we    = 1'b1;
                prev_waddr = after_reg;
                prev_wdata = {(after_reg != '0), slot_reg};
                count_next = count_reg + LW'(1);
                res_next   = make_rsp(FW'(slot_reg), FW'(after_reg), FW'(addr_reg),
                                      FW'(count_reg + LW'(1)), idll_pkg::ST_OK);
                state_next = RESP;
            end

            DEL_FREE:
            begin
                // push the slot onto the free chain
                next_we        = 1'b1;
                next_waddr     = addr_reg;
                next_wdata     = free_head_reg;
                prev_we        = 1'b1;
                prev_waddr     = addr_reg;
                prev_wdata     = '0;
                free_head_next = LW'(addr_reg);
                count_next     = count_reg - LW'(1);
                res_next       = make_rsp(FW'(addr_reg), FW'(free_head_reg), '0,
                                          FW'(count_reg - LW'(1)), idll_pkg::ST_OK);
                state_next     = RESP;
            end

            RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR;
            op_reg        <= '0;
            addr_reg      <= '0;
            after_reg     <= '0;
            slot_reg      <= '0;
            clr_reg       <= '0;
            free_head_reg <= LW'(1);
            count_reg     <= '0;
            res_reg       <= '0;
            rsp_data_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            after_reg     <= after_next;
            slot_reg      <= slot_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            res_reg       <= res_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/idll_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module idll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
